### sv/fmrle_pkg.sv
// ----------------------------------------------------------------------------
// fmrle_pkg - shared types and constants of the first-move run-length encoder
// Field widths, register indexes, reset values and the result item type.
// ----------------------------------------------------------------------------
`default_nettype none

package fmrle_pkg;

    // default parameter values
    localparam int unsigned NODE_BITS_DEF = 24;
    localparam int unsigned MASK_BITS_DEF = 16;

    // fixed field widths
    localparam int unsigned RUN_START_W  = 24;
    localparam int unsigned FIRST_MOVE_W = 4;
    localparam int unsigned MASK_FIELD_W = 16;
    localparam int unsigned COORD_W      = 16;
    localparam int unsigned HALF_W       = 15;
    localparam int unsigned SRC_INDEX_W  = 24;

    // stream widths
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 32;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_INDEX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SIDE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALL_MOVE_MASK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NO_MOVE_MASK  = 3'd5;

    localparam logic [MASK_FIELD_W-1:0] ALL_MOVE_RESET = 16'd255;

    // result buffer depth: one item may produce a closed run and a flush
    localparam int unsigned OBUF_DEPTH = 2;
    localparam int unsigned OBUF_CNT_W = 2;

    // one result item
    typedef struct packed {
        logic [RUN_START_W-1:0]  run_start;
        logic [FIRST_MOVE_W-1:0] first_move;
        logic                    row_end;
    } res_t;

    // which results one processed item pushes
    typedef struct packed {
        logic close;   // closed run, comes first
        logic flush;   // end-of-row flush
    } obuf_push_t;

endpackage

`default_nettype wire

### sv/fmrle_obuf.sv
// ----------------------------------------------------------------------------
// fmrle_obuf - two-entry result buffer
// Takes up to two result items per cycle in order and hands out one per
// handshake from the head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module fmrle_obuf (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire fmrle_pkg::res_t                       push_a,  // closed run
    input  wire fmrle_pkg::res_t                       push_b,  // flush
    input  wire fmrle_pkg::obuf_push_t                 push,
    input  wire logic                                  pop,
    output fmrle_pkg::res_t                            head,
    output logic [fmrle_pkg::OBUF_CNT_W-1:0]           count
);
    import fmrle_pkg::*;

    res_t                  slot0_reg, slot0_next;
    res_t                  slot1_reg, slot1_next;
    logic [OBUF_CNT_W-1:0] count_reg, count_next;

    res_t                  rem0;
    logic [OBUF_CNT_W-1:0] rem_cnt;
    res_t                  p0;
    logic [OBUF_CNT_W-1:0] np;

    // drop the head on pop, then append the pushed items in order
    always_comb
    begin
        rem0    = pop ? slot1_reg : slot0_reg;
        rem_cnt = count_reg - {{(OBUF_CNT_W-1){1'b0}}, pop};
        p0      = push.close ? push_a : push_b;
        np      = {{(OBUF_CNT_W-1){1'b0}}, push.close} +
                  {{(OBUF_CNT_W-1){1'b0}}, push.flush};

        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (rem_cnt)
            2'd0:
            begin
                slot0_next = p0;
                slot1_next = push_b;
            end
            2'd1:
            begin
                slot0_next = rem0;
                slot1_next = p0;
            end
            default:
            begin
                slot0_next = slot0_reg;
                slot1_next = slot1_reg;
            end
        endcase
        count_next = rem_cnt + np;
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // entries
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign head  = slot0_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

### sv/first_move_run_length_encoder_top.sv
// ----------------------------------------------------------------------------
// first_move_run_length_encoder_top - row encoder for a compressed path table
// Intersects per-node first-move masks along runs and emits each run's start
// node with the lowest move of the run mask; the last node flushes the row.
// ----------------------------------------------------------------------------
//  channel | ports                              | items
//  --------+------------------------------------+-------------------------------
//  in      | s_tvalid s_tready s_tdata s_tlast  | one node: mask, x, y, last
//  out     | m_tvalid m_tready m_tdata m_tlast  | one run: start, move, row end
//  cfg     | cfg_valid cfg_ready cfg_index/data | one register write
//
//  One node per cycle while the buffer has room: an input register feeds one
//  pass of mask logic that writes a two-entry result buffer. An item that both
//  closes a run and ends the row yields two results and waits in the input
//  register until the buffer has room, so the out port sets the pace there.
//  Items pass the input register, then the buffer. Reset leaves no run open,
//  node index zero and the all-move mask at 255. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module first_move_run_length_encoder_top #(
    parameter int unsigned NODE_BITS = fmrle_pkg::NODE_BITS_DEF,
    parameter int unsigned MASK_BITS = fmrle_pkg::MASK_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input nodes
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [fmrle_pkg::IN_DATA_W-1:0]     s_tdata,  // move_mask, node_x, node_y
    input  wire logic                                s_tlast,  // last_node
    // result runs
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [fmrle_pkg::OUT_DATA_W-1:0]         m_tdata,  // run_start, first_move, pad
    output logic                                     m_tlast,  // row_end
    // configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fmrle_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fmrle_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fmrle_pkg::*;

    localparam int unsigned EXT_W = NODE_BITS + RUN_START_W;

    // configuration registers
    logic [SRC_INDEX_W-1:0]  source_index_reg;
    logic [COORD_W-1:0]      source_x_reg;
    logic [COORD_W-1:0]      source_y_reg;
    logic [HALF_W-1:0]       half_side_reg;
    logic [MASK_FIELD_W-1:0] all_move_mask_reg;
    logic [MASK_FIELD_W-1:0] no_move_mask_reg;

    // input register
    logic                    in_valid_reg;
    logic [MASK_BITS-1:0]    in_mask_reg;
    logic [COORD_W-1:0]      in_x_reg;
    logic [COORD_W-1:0]      in_y_reg;
    logic                    in_last_reg;

    // run state
    logic [NODE_BITS-1:0]    node_counter_reg, node_counter_next;
    logic [NODE_BITS-1:0]    run_begin_reg, run_begin_next;
    logic [MASK_BITS-1:0]    run_mask_reg, run_mask_next;
    logic                    run_open_reg, run_open_next;

    // per-item logic
    logic                    src_hit;
    logic [COORD_W-1:0]      dx;
    logic [COORD_W-1:0]      dy;
    logic                    in_square;
    logic [MASK_BITS-1:0]    allowed;
    logic [MASK_BITS-1:0]    meet;
    logic                    close;
    logic [NODE_BITS-1:0]    new_begin;
    logic [MASK_BITS-1:0]    new_mask;
    logic [FIRST_MOVE_W-1:0] move_old;
    logic [FIRST_MOVE_W-1:0] move_new;
    logic [EXT_W-1:0]        old_begin_ext;
    logic [EXT_W-1:0]        new_begin_ext;
    logic [OBUF_CNT_W-1:0]   n_res;
    logic                    room;
    logic                    advance;

    // result buffer side
    res_t                    res_close;
    res_t                    res_flush;
    obuf_push_t              push;
    res_t                    head;
    logic [OBUF_CNT_W-1:0]   obuf_count;
    logic                    pop;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_index_reg  <= '0;
            source_x_reg      <= '0;
            source_y_reg      <= '0;
            half_side_reg     <= '0;
            all_move_mask_reg <= ALL_MOVE_RESET;
            no_move_mask_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SOURCE_INDEX:  source_index_reg  <= cfg_data[SRC_INDEX_W-1:0];
                REG_SOURCE_X:      source_x_reg      <= cfg_data[COORD_W-1:0];
                REG_SOURCE_Y:      source_y_reg      <= cfg_data[COORD_W-1:0];
                REG_HALF_SIDE:     half_side_reg     <= cfg_data[HALF_W-1:0];
                REG_ALL_MOVE_MASK: all_move_mask_reg <= cfg_data[MASK_FIELD_W-1:0];
                REG_NO_MOVE_MASK:  no_move_mask_reg  <= cfg_data[MASK_FIELD_W-1:0];
                default:           ;
            endcase
        end
    end

    // input register handshake
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mask_reg <= s_tdata[MASK_BITS-1:0];
            in_x_reg    <= s_tdata[MASK_FIELD_W +: COORD_W];
            in_y_reg    <= s_tdata[MASK_FIELD_W+COORD_W +: COORD_W];
            in_last_reg <= s_tlast;
        end
    end

    // node mask: source and its square allow every move, empty mask is replaced
    always_comb
    begin
        src_hit   = ({{RUN_START_W{1'b0}}, node_counter_reg} ==
                     {{NODE_BITS{1'b0}}, source_index_reg});
        dx        = (in_x_reg >= source_x_reg) ? (in_x_reg - source_x_reg)
                                               : (source_x_reg - in_x_reg);
        dy        = (in_y_reg >= source_y_reg) ? (in_y_reg - source_y_reg)
                                               : (source_y_reg - in_y_reg);
        in_square = (dx <= {1'b0, half_side_reg}) && (dy <= {1'b0, half_side_reg});
        if (src_hit || in_square)
            allowed = all_move_mask_reg[MASK_BITS-1:0];
        else if (in_mask_reg == '0)
            allowed = no_move_mask_reg[MASK_BITS-1:0];
        else
            allowed = in_mask_reg;
    end

    // run intersection and close decision
    always_comb
    begin
        meet      = run_mask_reg & allowed;
        close     = run_open_reg && (meet == '0);
        new_begin = (!run_open_reg || close) ? node_counter_reg : run_begin_reg;
        new_mask  = (!run_open_reg || close) ? allowed : meet;
    end

    // lowest set move of the closed run and of the run left after this node
    always_comb
    begin
        move_old = '0;
        move_new = '0;
        for (int k = MASK_BITS - 1; k >= 0; k--)
        begin
            if (run_mask_reg[k])
                move_old = FIRST_MOVE_W'(k);
            if (new_mask[k])
                move_new = FIRST_MOVE_W'(k);
        end
    end

    // result items
    always_comb
    begin
        old_begin_ext        = {{RUN_START_W{1'b0}}, run_begin_reg};
        new_begin_ext        = {{RUN_START_W{1'b0}}, new_begin};
        res_close.run_start  = old_begin_ext[RUN_START_W-1:0];
        res_close.first_move = move_old;
        res_close.row_end    = 1'b0;
        res_flush.run_start  = new_begin_ext[RUN_START_W-1:0];
        res_flush.first_move = move_new;
        res_flush.row_end    = 1'b1;
    end

    // advance when the buffer holds all results of this item
    always_comb
    begin
        n_res      = {{(OBUF_CNT_W-1){1'b0}}, close} +
                     {{(OBUF_CNT_W-1){1'b0}}, in_last_reg};
        room       = ({1'b0, obuf_count} + {1'b0, n_res}) <= (OBUF_CNT_W+1)'(OBUF_DEPTH);
        advance    = in_valid_reg && room;
        push.close = advance && close;
        push.flush = advance && in_last_reg;
    end

    // next run state; the last node of a row clears it
    always_comb
    begin
        if (in_last_reg)
        begin
            node_counter_next = '0;
            run_begin_next    = '0;
            run_mask_next     = '0;
            run_open_next     = 1'b0;
        end
        else
        begin
            node_counter_next = node_counter_reg + NODE_BITS'(1);
            run_begin_next    = new_begin;
            run_mask_next     = new_mask;
            run_open_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_counter_reg <= '0;
            run_begin_reg    <= '0;
            run_mask_reg     <= '0;
            run_open_reg     <= 1'b0;
        end
        else if (advance)
        begin
            node_counter_reg <= node_counter_next;
            run_begin_reg    <= run_begin_next;
            run_mask_reg     <= run_mask_next;
            run_open_reg     <= run_open_next;
        end
    end

    // result buffer
    fmrle_obuf u_obuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_a (res_close),
        .push_b (res_flush),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .count  (obuf_count)
    );

    // output port
    assign m_tvalid = (obuf_count != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {{(OUT_DATA_W-RUN_START_W-FIRST_MOVE_W){1'b0}},
                       head.first_move, head.run_start};
    assign m_tlast  = head.row_end;

    // buffer never holds more than its depth
    a_obuf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        obuf_count <= OBUF_CNT_W'(OBUF_DEPTH))
        else $error("result buffer overfilled");

    // the last node of a row leaves no open run and restarts the node index
    a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> !run_open_reg && (node_counter_reg == '0))
        else $error("row state not cleared after last node");

    // any other node leaves a run open
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_last_reg |=> run_open_reg)
        else $error("no open run after a node");

    // an item that pushes two results needs an empty buffer
    a_two_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.close && push.flush |-> obuf_count == '0)
        else $error("two results pushed into a non-empty buffer");

endmodule

`default_nettype wire
